// ----- design/matrix_factorization_sgd_update_top_assert.svh -----
// Assertion macros for the SGD matrix factorization update block
`ifndef MATRIX_FACTORIZATION_SGD_UPDATE_TOP_ASSERT_SVH
`define MATRIX_FACTORIZATION_SGD_UPDATE_TOP_ASSERT_SVH

// check the consequent in the same cycle
`define MSGD_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("msgd assertion failed");

// check the consequent in the next cycle
`define MSGD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("msgd assertion failed");

`endif

// ----- design/msgd_pkg.sv -----
// Shared types, codes and fixed-point helpers for the SGD update block
package msgd_pkg;

   localparam int ACC_W = 58;

   localparam logic [2:0] CMD_WRITE_USER = 3'd0;
   localparam logic [2:0] CMD_WRITE_ITEM = 3'd1;
   localparam logic [2:0] CMD_READ_USER  = 3'd2;
   localparam logic [2:0] CMD_READ_ITEM  = 3'd3;
   localparam logic [2:0] CMD_UPDATE     = 3'd4;

   localparam logic [1:0] CSR_LEARNING_RATE  = 2'd0;
   localparam logic [1:0] CSR_REGULARIZATION = 2'd1;
   localparam logic [1:0] CSR_RANK_IN_USE    = 2'd2;

   localparam logic [16:0] LEARNING_RATE_RESET  = 17'd655;
   localparam logic [16:0] REGULARIZATION_RESET = 17'd3277;
   localparam logic [5:0]  RANK_IN_USE_RESET    = 6'd16;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_WRITE_U,
      OP_WRITE_I,
      OP_READ_U,
      OP_READ_I,
      OP_UPDATE
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ACCESS,
      ST_RD_PASS,
      ST_RD_DRAIN,
      ST_ERROR,
      ST_WR_PASS,
      ST_WR_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic access;
      logic cnt_clear;
      logic issue;
      logic pass2;
      logic load_err;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   last_issue;
      logic   pipe_busy;
   } ctrl_status_type;

   typedef struct packed {
      logic        flag;
      logic [31:0] value;
   } sat_type;

   function automatic logic signed [49:0] rnd16(input logic signed [65:0] x);
      logic signed [65:0] t;
      t = x + 66'sd32768;
      return t[65:16];
   endfunction

   function automatic sat_type sat32(input logic signed [63:0] x);
      sat_type r;
      if (x > 64'sd2147483647) begin
         r.flag  = 1'b1;
         r.value = 32'h7FFF_FFFF;
      end else if (x < -64'sd2147483648) begin
         r.flag  = 1'b1;
         r.value = 32'h8000_0000;
      end else begin
         r.flag  = 1'b0;
         r.value = x[31:0];
      end
      return r;
   endfunction

endpackage

// ----- design/msgd_ctrl.sv -----
// Controller state machine for the SGD update block
module msgd_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  msgd_pkg::ctrl_status_type status,
   output msgd_pkg::ctrl_cmd_type    cmd
);
   import msgd_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture   = 1'b1;
               cmd.cnt_clear = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.op)
               OP_WRITE_U, OP_WRITE_I, OP_READ_U, OP_READ_I: state_in = ST_ACCESS;
               OP_UPDATE: state_in = ST_RD_PASS;
               default:   state_in = ST_DONE;
            endcase
         end
         ST_ACCESS: begin
            cmd.access = 1'b1;
            state_in   = ST_DONE;
         end
         ST_RD_PASS: begin
            cmd.issue = 1'b1;
            if (status.last_issue) begin
               state_in = ST_RD_DRAIN;
            end
         end
         ST_RD_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_ERROR;
            end
         end
         ST_ERROR: begin
            cmd.load_err  = 1'b1;
            cmd.cnt_clear = 1'b1;
            state_in      = ST_WR_PASS;
         end
         ST_WR_PASS: begin
            cmd.issue = 1'b1;
            cmd.pass2 = 1'b1;
            if (status.last_issue) begin
               state_in = ST_WR_DRAIN;
            end
         end
         ST_WR_DRAIN: begin
            cmd.pass2 = 1'b1;
            if (!status.pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign req_stall    = (state_ff != ST_IDLE);

endmodule

// ----- design/msgd_datapath.sv -----
// Datapath: factor tables, config registers, update pipeline and result register
module msgd_datapath #(
   parameter int USERS    = 4096,
   parameter int ITEMS    = 4096,
   parameter int RANK_MAX = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [2:0]                req_cmd,
   input  logic [11:0]               req_user_index,
   input  logic [11:0]               req_item_index,
   input  logic [4:0]                req_factor_index,
   input  logic signed [31:0]        req_write_value,
   input  logic signed [31:0]        req_rating,
   input  logic                      csr_write,
   input  logic [1:0]                csr_index,
   input  logic [16:0]               csr_write_data,
   input  msgd_pkg::ctrl_cmd_type    cmd,
   output msgd_pkg::ctrl_status_type status,
   output logic signed [31:0]        rsp_read_value,
   output logic signed [31:0]        rsp_prediction_error,
   output logic                      rsp_saturated
);
   import msgd_pkg::*;

   localparam int FW = (RANK_MAX > 1) ? $clog2(RANK_MAX) : 1;
   localparam int RW = $clog2(RANK_MAX + 1);
   localparam int UW = (USERS > 1) ? $clog2(USERS) : 1;
   localparam int IW = (ITEMS > 1) ? $clog2(ITEMS) : 1;
   localparam int UDEPTH = 2 ** (UW + FW);
   localparam int IDEPTH = 2 ** (IW + FW);

   logic [31:0] user_mem [UDEPTH];
   logic [31:0] item_mem [IDEPTH];

   logic [16:0] lr_ff, reg_ff;
   logic [5:0]  rank_ff;

   op_type             op_ff, op_in;
   logic [UW-1:0]      urow_ff;
   logic [IW-1:0]      irow_ff;
   logic [FW-1:0]      fidx_ff;
   logic signed [31:0] wv_ff, rating_ff;
   logic [RW-1:0]      cnt_ff, rank_eff;

   logic [31:0] user_ext, item_ext, factor_ext;
   logic        u_ok, i_ok, f_ok;

   logic signed [31:0] u_rd_ff, i_rd_ff;
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic [FW-1:0]      f1_ff, f2_ff, f3_ff, f4_ff;
   logic signed [31:0] uo2_ff, vo2_ff, uo3_ff, vo3_ff, uo4_ff, vo4_ff;
   logic signed [63:0] puv_ff, pev_ff, peu_ff;
   logic signed [49:0] pru_ff, prv_ff, lu_ff, lv_ff;
   logic signed [31:0] gu_ff, gv_ff, err_ff;
   logic signed [ACC_W-1:0] acc_ff, diff;
   logic               sat_ff;
   logic signed [17:0] lr_s, reg_s;
   logic signed [65:0] gsum_u, gsum_v;
   sat_type            gu_s, gv_s, nu_s, nv_s, err_s;

   logic                 rd_en, u_we, i_we, wr_back;
   logic [UW+FW-1:0]     u_raddr, u_waddr;
   logic [IW+FW-1:0]     i_raddr, i_waddr;
   logic [31:0]          u_wdata, i_wdata;

   assign user_ext   = 32'(req_user_index);
   assign item_ext   = 32'(req_item_index);
   assign factor_ext = 32'(req_factor_index);
   assign u_ok = user_ext < USERS;
   assign i_ok = item_ext < ITEMS;
   assign f_ok = factor_ext < RANK_MAX;

   always_comb begin
      case (req_cmd)
         CMD_WRITE_USER: op_in = (u_ok && f_ok) ? OP_WRITE_U : OP_NONE;
         CMD_WRITE_ITEM: op_in = (i_ok && f_ok) ? OP_WRITE_I : OP_NONE;
         CMD_READ_USER:  op_in = (u_ok && f_ok) ? OP_READ_U : OP_NONE;
         CMD_READ_ITEM:  op_in = (i_ok && f_ok) ? OP_READ_I : OP_NONE;
         CMD_UPDATE:     op_in = (u_ok && i_ok) ? OP_UPDATE : OP_NONE;
         default:        op_in = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff   <= LEARNING_RATE_RESET;
         reg_ff  <= REGULARIZATION_RESET;
         rank_ff <= RANK_IN_USE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LEARNING_RATE:  lr_ff   <= csr_write_data;
            CSR_REGULARIZATION: reg_ff  <= csr_write_data;
            CSR_RANK_IN_USE:    rank_ff <= csr_write_data[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= OP_NONE;
      end else if (cmd.capture) begin
         op_ff <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         urow_ff   <= user_ext[UW-1:0];
         irow_ff   <= item_ext[IW-1:0];
         fidx_ff   <= factor_ext[FW-1:0];
         wv_ff     <= req_write_value;
         rating_ff <= req_rating;
      end
   end

   always_comb begin
      if (rank_ff == '0) begin
         rank_eff = RW'(1);
      end else if (32'(rank_ff) > RANK_MAX) begin
         rank_eff = RW'(RANK_MAX);
      end else begin
         rank_eff = RW'(rank_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_clear) begin
         cnt_ff <= '0;
      end else if (cmd.issue) begin
         cnt_ff <= cnt_ff + RW'(1);
      end
   end

   assign status.op         = op_ff;
   assign status.last_issue = (cnt_ff == rank_eff - RW'(1));
   assign status.pipe_busy  = v1_ff || v2_ff || v3_ff || v4_ff;

   assign rd_en   = cmd.access || cmd.issue;
   assign wr_back = v4_ff && cmd.pass2;
   assign u_raddr = cmd.access ? {urow_ff, fidx_ff} : {urow_ff, cnt_ff[FW-1:0]};
   assign i_raddr = cmd.access ? {irow_ff, fidx_ff} : {irow_ff, cnt_ff[FW-1:0]};
   assign u_waddr = cmd.access ? {urow_ff, fidx_ff} : {urow_ff, f4_ff};
   assign i_waddr = cmd.access ? {irow_ff, fidx_ff} : {irow_ff, f4_ff};
   assign u_we    = (cmd.access && op_ff == OP_WRITE_U) || wr_back;
   assign i_we    = (cmd.access && op_ff == OP_WRITE_I) || wr_back;
   assign u_wdata = cmd.access ? wv_ff : nu_s.value;
   assign i_wdata = cmd.access ? wv_ff : nv_s.value;

   always_ff @(posedge clock) begin
      if (u_we) begin
         user_mem[u_waddr] <= u_wdata;
      end
      if (rd_en) begin
         u_rd_ff <= user_mem[u_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (i_we) begin
         item_mem[i_waddr] <= i_wdata;
      end
      if (rd_en) begin
         i_rd_ff <= item_mem[i_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign lr_s  = {1'b0, lr_ff};
   assign reg_s = {1'b0, reg_ff};

   assign gsum_u = 66'(pev_ff) + 66'(pru_ff);
   assign gsum_v = 66'(peu_ff) + 66'(prv_ff);
   assign gu_s   = sat32(64'(rnd16(gsum_u)));
   assign gv_s   = sat32(64'(rnd16(gsum_v)));
   assign nu_s   = sat32(64'(uo4_ff) - 64'(rnd16(66'(lu_ff))));
   assign nv_s   = sat32(64'(vo4_ff) - 64'(rnd16(66'(lv_ff))));
   assign diff   = acc_ff - ACC_W'(rating_ff);
   assign err_s  = sat32(64'(diff));

   always_ff @(posedge clock) begin
      f1_ff  <= cnt_ff[FW-1:0];
      f2_ff  <= f1_ff;
      f3_ff  <= f2_ff;
      f4_ff  <= f3_ff;
      uo2_ff <= u_rd_ff;
      vo2_ff <= i_rd_ff;
      puv_ff <= u_rd_ff * i_rd_ff;
      pev_ff <= err_ff * i_rd_ff;
      peu_ff <= err_ff * u_rd_ff;
      pru_ff <= reg_s * u_rd_ff;
      prv_ff <= reg_s * i_rd_ff;
      uo3_ff <= uo2_ff;
      vo3_ff <= vo2_ff;
      gu_ff  <= gu_s.value;
      gv_ff  <= gv_s.value;
      uo4_ff <= uo3_ff;
      vo4_ff <= vo3_ff;
      lu_ff  <= lr_s * gu_ff;
      lv_ff  <= lr_s * gv_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         acc_ff <= '0;
      end else if (v2_ff && !cmd.pass2) begin
         acc_ff <= acc_ff + ACC_W'(rnd16(66'(puv_ff)));
      end
      if (cmd.load_err) begin
         err_ff <= err_s.value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sat_ff <= 1'b0;
      end else begin
         sat_ff <= sat_ff
                 || (cmd.load_err && err_s.flag)
                 || (v2_ff && cmd.pass2 && (gu_s.flag || gv_s.flag))
                 || (wr_back && (nu_s.flag || nv_s.flag));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         case (op_ff)
            OP_READ_U: rsp_read_value <= u_rd_ff;
            OP_READ_I: rsp_read_value <= i_rd_ff;
            default:   rsp_read_value <= '0;
         endcase
         rsp_prediction_error <= (op_ff == OP_UPDATE) ? err_ff : '0;
         rsp_saturated        <= (op_ff == OP_UPDATE) ? sat_ff : 1'b0;
      end
   end

endmodule

// ----- design/matrix_factorization_sgd_update_top.sv -----
// Top level of the SGD matrix factorization update block
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  cmd, user/item/factor index, write value, rating
//   rsp      out        rsp_valid / rsp_stall  read value, prediction error, saturated
//   csr      in         csr_valid / csr_ready  register index, write data
//
// A word access goes through decode, one table access and done; an update makes two
// passes over the factor tables (a read pass, then a pass that reads again and writes back),
// each followed by a drain of the pipeline, with the prediction error loaded in between.
// One item is in work at a time; a finished result waits in the output register
// while the next item is accepted, and a new result waits until that register frees.
// Synchronous active-high reset; the factor tables are not cleared.
`include "matrix_factorization_sgd_update_top_assert.svh"

module matrix_factorization_sgd_update_top #(
   parameter int USERS    = 4096,
   parameter int ITEMS    = 4096,
   parameter int RANK_MAX = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic [11:0]        req_user_index,
   input  logic [11:0]        req_item_index,
   input  logic [4:0]         req_factor_index,
   input  logic signed [31:0] req_write_value,
   input  logic signed [31:0] req_rating,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_read_value,
   output logic signed [31:0] rsp_prediction_error,
   output logic               rsp_saturated,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [16:0]        csr_write_data
);
   import msgd_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic            csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   msgd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   msgd_datapath #(
      .USERS    (USERS),
      .ITEMS    (ITEMS),
      .RANK_MAX (RANK_MAX)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_cmd              (req_cmd),
      .req_user_index       (req_user_index),
      .req_item_index       (req_item_index),
      .req_factor_index     (req_factor_index),
      .req_write_value      (req_write_value),
      .req_rating           (req_rating),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .cmd                  (cmd),
      .status               (status),
      .rsp_read_value       (rsp_read_value),
      .rsp_prediction_error (rsp_prediction_error),
      .rsp_saturated        (rsp_saturated)
   );

   `MSGD_ASSERT_SAME(a_busy_stalls_req, status.pipe_busy, req_stall)
   `MSGD_ASSERT_SAME(a_no_result_overwrite, cmd.load_rsp, !rsp_valid || !rsp_stall)
   `MSGD_ASSERT_NEXT(a_capture_then_stall, cmd.capture, req_stall)

endmodule

// ----- tb/sv/matrix_factorization_sgd_update_top_tb.sv -----
// Self-checking testbench for the SGD matrix factorization update block
module matrix_factorization_sgd_update_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import msgd_pkg::*;

   localparam int FACTORS = 32;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] CMD_RESERVED_LAST = 3'd7;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [11:0]        user;
      logic [11:0]        item;
      logic [4:0]         factor;
      logic signed [31:0] write_value;
      logic signed [31:0] rating;
   } sgd_req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic signed [31:0] prediction_error;
      logic               saturated;
   } sgd_rsp_type;

   typedef struct packed {
      logic        is_item;
      logic [11:0] row;
      logic [4:0]  factor;
   } word_addr_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY
   } stall_kind_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_cmd = '0;
   logic [11:0]        req_user_index = '0;
   logic [11:0]        req_item_index = '0;
   logic [4:0]         req_factor_index = '0;
   logic signed [31:0] req_write_value = '0;
   logic signed [31:0] req_rating = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_read_value;
   logic signed [31:0] rsp_prediction_error;
   logic               rsp_saturated;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [16:0]        csr_write_data = '0;

   sgd_req_type   pending_reqs[$];
   sgd_rsp_type   expected_rsps[$];
   word_addr_type written_words[$];
   sgd_req_type   offered;

   logic signed [31:0] user_words[logic [16:0]];
   logic signed [31:0] item_words[logic [16:0]];
   logic [16:0] cfg_learning_rate = LEARNING_RATE_RESET;
   logic [16:0] cfg_regularization = REGULARIZATION_RESET;
   logic [5:0]  cfg_rank = RANK_IN_USE_RESET;

   logic [11:0] pool_users[3];
   logic [11:0] pool_items[3];

   int             queued_count = 0;
   int             accepted_count = 0;
   int             mismatch_count = 0;
   logic           req_taken = 1'b0;
   int             burst_left = 0;
   int             gap_left = 0;
   int             hold_left = 0;
   bit             long_hold_done = 1'b0;
   int             mode_left = 0;
   stall_kind_type stall_mode = STALL_NONE;

   matrix_factorization_sgd_update_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_user_index(req_user_index),
      .req_item_index(req_item_index),
      .req_factor_index(req_factor_index),
      .req_write_value(req_write_value),
      .req_rating(req_rating),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_read_value(rsp_read_value),
      .rsp_prediction_error(rsp_prediction_error),
      .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int clamp_rank(input logic [5:0] r);
      if (r == 0) return 1;
      if (r > FACTORS) return FACTORS;
      return int'(r);
   endfunction

   function automatic longint round_q16(input longint x);
      longint t;
      t = x + 64'sd32768;
      return t >>> 16;
   endfunction

   function automatic logic signed [31:0] clip_q32(input longint x, inout bit flag);
      if (x > 64'sd2147483647) begin
         flag = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (x < -64'sd2147483648) begin
         flag = 1'b1;
         return 32'sh8000_0000;
      end
      return x[31:0];
   endfunction

   function automatic sgd_rsp_type apply_request(input sgd_req_type r);
      sgd_rsp_type        rsp;
      int                 eff;
      longint             acc;
      longint             lr;
      longint             rg;
      logic signed [31:0] uo[FACTORS];
      logic signed [31:0] vo[FACTORS];
      logic signed [31:0] err;
      logic signed [31:0] gu;
      logic signed [31:0] gv;
      bit                 sat;
      rsp = '0;
      case (r.cmd)
         CMD_WRITE_USER: user_words[{r.user, r.factor}] = r.write_value;
         CMD_WRITE_ITEM: item_words[{r.item, r.factor}] = r.write_value;
         CMD_READ_USER: rsp.read_value = user_words[{r.user, r.factor}];
         CMD_READ_ITEM: rsp.read_value = item_words[{r.item, r.factor}];
         CMD_UPDATE: begin
            eff = clamp_rank(cfg_rank);
            lr = longint'(cfg_learning_rate);
            rg = longint'(cfg_regularization);
            acc = 0;
            sat = 1'b0;
            for (int f = 0; f < eff; f++) begin
               uo[f] = user_words[{r.user, 5'(f)}];
               vo[f] = item_words[{r.item, 5'(f)}];
               acc += round_q16(longint'(uo[f]) * longint'(vo[f]));
            end
            err = clip_q32(acc - longint'(r.rating), sat);
            for (int f = 0; f < eff; f++) begin
               gu = clip_q32(round_q16(longint'(err) * longint'(vo[f])
                                       + rg * longint'(uo[f])), sat);
               gv = clip_q32(round_q16(longint'(err) * longint'(uo[f])
                                       + rg * longint'(vo[f])), sat);
               user_words[{r.user, 5'(f)}] =
                  clip_q32(longint'(uo[f]) - round_q16(lr * longint'(gu)), sat);
               item_words[{r.item, 5'(f)}] =
                  clip_q32(longint'(vo[f]) - round_q16(lr * longint'(gv)), sat);
            end
            rsp.prediction_error = err;
            rsp.saturated = sat;
         end
         default: ;
      endcase
      return rsp;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
   endtask

   // accept items, predict, and check results
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            expected_rsps.insert(expected_rsps.size(), apply_request(offered));
            accepted_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected result", rsp_read_value, '0);
            end else begin
               sgd_rsp_type want;
               want = expected_rsps.pop_front();
               if (rsp_read_value !== want.read_value)
                  report_mismatch("read_value", rsp_read_value, want.read_value);
               if (rsp_prediction_error !== want.prediction_error)
                  report_mismatch("prediction_error", rsp_prediction_error,
                                  want.prediction_error);
               if (rsp_saturated !== want.saturated)
                  report_mismatch("saturated", 32'(rsp_saturated), 32'(want.saturated));
            end
         end
      end
   end

   // offer items in bursts with gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            offered = pending_reqs.pop_front();
            req_cmd <= offered.cmd;
            req_user_index <= offered.user;
            req_item_index <= offered.item;
            req_factor_index <= offered.factor;
            req_write_value <= offered.write_value;
            req_rating <= offered.rating;
            req_valid <= 1'b1;
            burst_left--;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // stall results on a pattern of their own, with one long hold
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!long_hold_done && accepted_count >= 350 && pending_reqs.size() > 20) begin
         long_hold_done = 1'b1;
         hold_left = 600;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_kind_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (stall_mode)
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 30);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 75);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [16:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_LEARNING_RATE: cfg_learning_rate = data;
         CSR_REGULARIZATION: cfg_regularization = data;
         CSR_RANK_IN_USE: cfg_rank = data[5:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (accepted_count != queued_count || expected_rsps.size() != 0)
         @(negedge clock);
   endtask

   task automatic queue_req(input logic [2:0] cmd, input logic [11:0] user,
                            input logic [11:0] item, input logic [4:0] factor,
                            input logic [31:0] wval, input logic [31:0] rating);
      sgd_req_type   r;
      word_addr_type a;
      r = {cmd, user, item, factor, wval, rating};
      pending_reqs.insert(pending_reqs.size(), r);
      queued_count++;
      if (cmd == CMD_WRITE_USER) begin
         a = {1'b0, user, factor};
         written_words.insert(written_words.size(), a);
      end else if (cmd == CMD_WRITE_ITEM) begin
         a = {1'b1, item, factor};
         written_words.insert(written_words.size(), a);
      end
   endtask

   function automatic logic [31:0] small_word();
      int v;
      v = int'($urandom_range(0, 262144)) - 131072;
      return v;
   endfunction

   function automatic logic [31:0] edge_word();
      case ($urandom_range(0, 4))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'h0001_0000;
         default: return 32'hFFFF_0000;
      endcase
   endfunction

   function automatic logic [31:0] rand_word();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 70) return small_word();
      if (sel < 85) return $urandom;
      return edge_word();
   endfunction

   function automatic logic [31:0] rand_rating();
      int sel;
      int v;
      sel = $urandom_range(0, 99);
      v = int'($urandom_range(0, 1048576)) - 524288;
      if (sel < 75) return v;
      if (sel < 85) return $urandom;
      return edge_word();
   endfunction

   task automatic refill_pool(input int eff);
      for (int i = 0; i < 3; i++) begin
         for (int f = 0; f < eff; f++) begin
            queue_req(CMD_WRITE_USER, pool_users[i], 12'($urandom), 5'(f),
                      small_word(), $urandom);
            queue_req(CMD_WRITE_ITEM, 12'($urandom), pool_items[i], 5'(f),
                      small_word(), $urandom);
         end
      end
   endtask

   task automatic queue_random_item();
      int            sel;
      logic [11:0]   row;
      word_addr_type a;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
         queue_req(CMD_UPDATE, pool_users[$urandom_range(0, 2)],
                   pool_items[$urandom_range(0, 2)], 5'($urandom), $urandom,
                   rand_rating());
      end else if (sel < 75) begin
         if ($urandom_range(0, 1) == 0)
            row = $urandom_range(0, 1) ? pool_users[$urandom_range(0, 2)] : 12'($urandom);
         else
            row = $urandom_range(0, 1) ? pool_items[$urandom_range(0, 2)] : 12'($urandom);
         if ($urandom_range(0, 1) == 0)
            queue_req(CMD_WRITE_USER, row, 12'($urandom), 5'($urandom), rand_word(),
                      $urandom);
         else
            queue_req(CMD_WRITE_ITEM, 12'($urandom), row, 5'($urandom), rand_word(),
                      $urandom);
      end else if (sel < 93) begin
         a = written_words[$urandom_range(0, written_words.size() - 1)];
         if (a.is_item)
            queue_req(CMD_READ_ITEM, 12'($urandom), a.row, a.factor, $urandom, $urandom);
         else
            queue_req(CMD_READ_USER, a.row, 12'($urandom), a.factor, $urandom, $urandom);
      end else begin
         queue_req(3'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST)),
                   12'($urandom), 12'($urandom), 5'($urandom), $urandom, $urandom);
      end
   endtask

   initial begin
      logic [16:0] lr_set[6];
      logic [16:0] reg_set[6];
      logic [5:0]  rank_set[6];
      lr_set = '{17'd655, 17'd0, 17'd6554, 17'd131071, 17'd0, 17'd1};
      reg_set = '{17'd3277, 17'd0, 17'd655, 17'd131071, 17'd0, 17'd65536};
      rank_set = '{6'd16, 6'd0, 6'd63, 6'd32, 6'd1, 6'd1};
      lr_set[4] = 17'($urandom_range(0, 13107));
      reg_set[4] = 17'($urandom_range(0, 131071));
      rank_set[4] = 6'($urandom_range(1, 32));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_csr(CSR_RANK_IN_USE, {11'($urandom), 6'd2});
      queue_req(CMD_WRITE_USER, 12'd0, 12'($urandom), 5'd0, 32'h7FFF_FFFF, $urandom);
      queue_req(CMD_WRITE_USER, 12'd0, 12'($urandom), 5'd1, 32'h8000_0000, $urandom);
      queue_req(CMD_WRITE_ITEM, 12'($urandom), 12'd4095, 5'd0, 32'h7FFF_FFFF, $urandom);
      queue_req(CMD_WRITE_ITEM, 12'($urandom), 12'd4095, 5'd1, 32'h0001_0000, $urandom);
      queue_req(CMD_READ_USER, 12'd0, 12'($urandom), 5'd0, $urandom, $urandom);
      queue_req(CMD_READ_USER, 12'd0, 12'($urandom), 5'd1, $urandom, $urandom);
      queue_req(CMD_READ_ITEM, 12'($urandom), 12'd4095, 5'd1, $urandom, $urandom);
      queue_req(CMD_UPDATE, 12'd0, 12'd4095, 5'($urandom), $urandom, 32'd0);
      queue_req(CMD_READ_USER, 12'd0, 12'($urandom), 5'd0, $urandom, $urandom);
      queue_req(CMD_READ_ITEM, 12'($urandom), 12'd4095, 5'd0, $urandom, $urandom);
      queue_req(CMD_WRITE_USER, 12'd4095, 12'($urandom), 5'd31, $urandom, $urandom);
      queue_req(CMD_READ_USER, 12'd4095, 12'($urandom), 5'd31, $urandom, $urandom);
      queue_req(CMD_WRITE_ITEM, 12'($urandom), 12'd0, 5'd31, $urandom, $urandom);
      queue_req(CMD_READ_ITEM, 12'($urandom), 12'd0, 5'd31, $urandom, $urandom);
      queue_req(CMD_WRITE_USER, 12'd1, 12'($urandom), 5'd0, 32'h0001_8000, $urandom);
      queue_req(CMD_WRITE_USER, 12'd1, 12'($urandom), 5'd1, 32'hFFFF_8000, $urandom);
      queue_req(CMD_WRITE_ITEM, 12'($urandom), 12'd2, 5'd0, 32'h0002_0000, $urandom);
      queue_req(CMD_WRITE_ITEM, 12'($urandom), 12'd2, 5'd1, 32'h0001_0000, $urandom);
      queue_req(CMD_UPDATE, 12'd1, 12'd2, 5'($urandom), $urandom, 32'h7FFF_FFFF);
      queue_req(CMD_UPDATE, 12'd1, 12'd2, 5'($urandom), $urandom, 32'h8000_0000);
      queue_req(CMD_UPDATE, 12'd1, 12'd2, 5'($urandom), $urandom, 32'h0002_0000);
      queue_req(CMD_RESERVED_FIRST, 12'($urandom), 12'($urandom), 5'($urandom),
                $urandom, $urandom);
      queue_req(3'd6, 12'($urandom), 12'($urandom), 5'($urandom), $urandom, $urandom);
      queue_req(CMD_RESERVED_LAST, 12'($urandom), 12'($urandom), 5'($urandom),
                $urandom, $urandom);
      queue_req(CMD_READ_USER, 12'd1, 12'($urandom), 5'd1, $urandom, $urandom);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         write_csr(CSR_LEARNING_RATE, lr_set[p]);
         write_csr(CSR_REGULARIZATION, reg_set[p]);
         write_csr(CSR_RANK_IN_USE, {11'($urandom), rank_set[p]});
         if (p == 0)
            write_csr(CSR_UNUSED, 17'($urandom));
         pool_users = '{12'd0, 12'd4095, 12'($urandom)};
         pool_items = '{12'd0, 12'd4095, 12'($urandom)};
         refill_pool(clamp_rank(rank_set[p]));
         repeat (150) queue_random_item();
         wait_drained();
      end

      repeat (50) @(negedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #10ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/msgd_pkg.sv
design/msgd_ctrl.sv
design/msgd_datapath.sv
design/matrix_factorization_sgd_update_top.sv
tb/sv/matrix_factorization_sgd_update_top_tb.sv
